>>> hw/rtl/canrfq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// canrfq_pkg
// Shared types, codes and sizes of the CAN receive queue and route table.
// ----------------------------------------------------------------------------
package canrfq_pkg;

	localparam int RING_DEPTH  = 16;
	localparam int ROUTE_SLOTS = 8;

	localparam int RingIdxW  = $clog2(RING_DEPTH);
	localparam int RouteIdxW = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
	localparam int RouteCntW = $clog2(ROUTE_SLOTS + 1);

	localparam logic [3:0] DLC_MAX = 4'd8;

	// request codes
	localparam logic [1:0] REQ_FRAME = 2'd0;
	localparam logic [1:0] REQ_POP   = 2'd1;
	localparam logic [1:0] REQ_ROUTE = 2'd2;

	// status codes
	localparam logic [3:0] STAT_OK       = 4'd0;
	localparam logic [3:0] STAT_FILTERED = 4'd1;
	localparam logic [3:0] STAT_OVERFLOW = 4'd2;
	localparam logic [3:0] STAT_RD_ERR   = 4'd3;
	localparam logic [3:0] STAT_EMPTY    = 4'd4;
	localparam logic [3:0] STAT_NO_ROUTE = 4'd5;
	localparam logic [3:0] STAT_BAD_ID   = 4'd6;
	localparam logic [3:0] STAT_FULL     = 4'd7;
	localparam logic [3:0] STAT_DUP      = 4'd8;

	typedef struct packed {
		logic [1:0]  req_type;
		logic        read_failed;
		logic        extended_flag;
		logic        remote_flag;
		logic [3:0]  length_code;
		logic [10:0] frame_ident;
		logic [63:0] payload_in;
		logic [31:0] stamp_in;
		logic [31:0] route_key;
		logic [7:0]  handler_tag;
	} can_req_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [10:0] out_ident;
		logic [3:0]  out_length;
		logic [63:0] out_payload;
		logic [31:0] out_stamp;
		logic        route_found;
		logic [7:0]  out_handler;
		logic [31:0] received_total;
		logic [31:0] filtered_total;
		logic [31:0] overflow_total;
		logic [31:0] error_total;
	} can_rsp_t;

	typedef struct packed {
		logic [63:0] payload;
		logic [31:0] stamp;
		logic [3:0]  length;
		logic [10:0] ident;
	} ring_entry_t;

	typedef struct packed {
		logic        lookup;
		logic        add;
		logic [10:0] key;
		logic [7:0]  handler;
	} route_cmd_t;

	typedef struct packed {
		logic                 done;
		logic                 hit;
		logic [7:0]           handler;
		logic [RouteCntW-1:0] count;
	} route_stat_t;

	function automatic logic [RingIdxW-1:0] ring_next(input logic [RingIdxW-1:0] idx);
		return (idx == RingIdxW'(RING_DEPTH - 1)) ? '0 : RingIdxW'(idx + 1'b1);
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/can_rx_filter_queue_router_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// can_rx_filter_queue_router_core
// CAN receive filter and frame ring with identifier routing and counters.
// ----------------------------------------------------------------------------
// frames, empty-ring pops, rejected route adds, adds to an empty table and
//   unused codes: result the cycle after acceptance; busy stays low throughout
// pop: result after the ring read and the route scan over the entries up to
//   the first match (0 to N, N registered routes); busy until the result
// route add: result after the same scan, over 1 to N entries
// arst_n clears ring pointers, route count and counters; no memory clearing
// ----------------------------------------------------------------------------
module can_rx_filter_queue_router_core (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  canrfq_pkg::can_req_t req,
	output logic                 done,
	output canrfq_pkg::can_rsp_t rsp
);
	import canrfq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RING  = 3'b010,
		ST_ROUTE = 3'b100
	} state_t;

	state_t               state_q;
	ring_entry_t          ring_mem [RING_DEPTH];
	ring_entry_t          ring_rd_s1;
	logic [RingIdxW-1:0]  wr_idx_q;
	logic [RingIdxW-1:0]  rd_idx_q;
	logic [31:0]          rx_cnt_q;
	logic [31:0]          filt_cnt_q;
	logic [31:0]          ovf_cnt_q;
	logic [31:0]          err_cnt_q;
	logic                 done_q;
	logic [3:0]           status_q;
	logic                 pop_q;
	logic                 found_q;
	logic [7:0]           handler_q;
	logic                 add_op_q;
	logic [10:0]          add_key_q;
	logic [7:0]           add_hnd_q;

	logic                 accept;
	logic                 frame_bad;
	logic                 ring_full;
	logic                 ring_empty;
	logic                 push;
	logic                 pop;
	logic                 key_bad;
	logic                 table_full;
	logic                 table_empty;
	route_cmd_t           rcmd;
	route_stat_t          rstat;

	assign accept      = start && !busy;
	assign busy        = (state_q != ST_IDLE);
	assign frame_bad   = req.extended_flag || req.remote_flag || (req.length_code > DLC_MAX);
	assign ring_full   = (ring_next(wr_idx_q) == rd_idx_q);
	assign ring_empty  = (rd_idx_q == wr_idx_q);
	assign push        = accept && (req.req_type == REQ_FRAME) && !req.read_failed &&
	                     !frame_bad && !ring_full;
	assign pop         = accept && (req.req_type == REQ_POP) && !ring_empty;
	assign key_bad     = (req.route_key[31:11] != '0);
	assign table_full  = (rstat.count >= RouteCntW'(ROUTE_SLOTS));
	assign table_empty = (rstat.count == '0);

	canrfq_route u_route (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (rcmd),
		.stat   (rstat)
	);

	// ring memory
	always_ff @(posedge clk) begin
		if (push) begin
			ring_mem[wr_idx_q] <= '{payload: req.payload_in, stamp: req.stamp_in,
			                        length: req.length_code, ident: req.frame_ident};
		end
		if (pop) begin
			ring_rd_s1 <= ring_mem[rd_idx_q];
		end
	end

	always_comb begin
		rcmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && (req.req_type == REQ_ROUTE) && !key_bad && !table_full) begin
					rcmd.key     = req.route_key[10:0];
					rcmd.handler = req.handler_tag;
					rcmd.lookup  = !table_empty;
					rcmd.add     = table_empty;
				end
			end
			ST_RING: begin
				rcmd.key    = ring_rd_s1.ident;
				rcmd.lookup = !table_empty;
			end
			ST_ROUTE: begin
				rcmd.key     = add_key_q;
				rcmd.handler = add_hnd_q;
				rcmd.add     = rstat.done && add_op_q && !rstat.hit;
			end
			default: begin
				rcmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wr_idx_q   <= '0;
			rd_idx_q   <= '0;
			rx_cnt_q   <= '0;
			filt_cnt_q <= '0;
			ovf_cnt_q  <= '0;
			err_cnt_q  <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.req_type)
							REQ_FRAME: begin
								done_q <= 1'b1;
								if (req.read_failed) begin
									err_cnt_q <= err_cnt_q + 32'd1;
								end else begin
									rx_cnt_q <= rx_cnt_q + 32'd1;
									if (frame_bad) begin
										filt_cnt_q <= filt_cnt_q + 32'd1;
									end else if (ring_full) begin
										ovf_cnt_q <= ovf_cnt_q + 32'd1;
									end else begin
										wr_idx_q <= ring_next(wr_idx_q);
									end
								end
							end
							REQ_POP: begin
								if (ring_empty) begin
									done_q <= 1'b1;
								end else begin
									rd_idx_q <= ring_next(rd_idx_q);
									state_q  <= ST_RING;
								end
							end
							REQ_ROUTE: begin
								if (key_bad || table_full || table_empty) begin
									done_q <= 1'b1;
								end else begin
									state_q <= ST_ROUTE;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_RING: begin
					if (table_empty) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_ROUTE;
					end
				end
				ST_ROUTE: begin
					if (rstat.done) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result word fields
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					pop_q     <= 1'b0;
					found_q   <= 1'b0;
					handler_q <= '0;
					add_op_q  <= 1'b1;
					add_key_q <= req.route_key[10:0];
					add_hnd_q <= req.handler_tag;
					status_q  <= STAT_OK;
					case (req.req_type)
						REQ_FRAME: begin
							if (req.read_failed) begin
								status_q <= STAT_RD_ERR;
							end else if (frame_bad) begin
								status_q <= STAT_FILTERED;
							end else if (ring_full) begin
								status_q <= STAT_OVERFLOW;
							end
						end
						REQ_POP: begin
							add_op_q <= 1'b0;
							if (ring_empty) begin
								status_q <= STAT_EMPTY;
							end
						end
						REQ_ROUTE: begin
							if (key_bad) begin
								status_q <= STAT_BAD_ID;
							end else if (table_full) begin
								status_q <= STAT_FULL;
							end
						end
						default: begin
							status_q <= STAT_OK;
						end
					endcase
				end
			end
			ST_RING: begin
				pop_q    <= 1'b1;
				status_q <= STAT_NO_ROUTE;
			end
			ST_ROUTE: begin
				if (rstat.done) begin
					if (add_op_q) begin
						status_q <= rstat.hit ? STAT_DUP : STAT_OK;
					end else if (rstat.hit) begin
						status_q  <= STAT_OK;
						found_q   <= 1'b1;
						handler_q <= rstat.handler;
					end
				end
			end
			default: begin
				status_q <= STAT_OK;
			end
		endcase
	end

	assign done = done_q;

	always_comb begin
		rsp.status         = status_q;
		rsp.out_ident      = pop_q ? ring_rd_s1.ident : '0;
		rsp.out_length     = pop_q ? ring_rd_s1.length : '0;
		rsp.out_payload    = pop_q ? ring_rd_s1.payload : '0;
		rsp.out_stamp      = pop_q ? ring_rd_s1.stamp : '0;
		rsp.route_found    = found_q;
		rsp.out_handler    = handler_q;
		rsp.received_total = rx_cnt_q;
		rsp.filtered_total = filt_cnt_q;
		rsp.overflow_total = ovf_cnt_q;
		rsp.error_total    = err_cnt_q;
	end

	a_result_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result word while a request is still in flight");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RING) |-> ($past(rd_idx_q) != $past(wr_idx_q)))
		else $error("ring read issued on an empty ring");

	a_route_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rstat.done |-> (state_q == ST_ROUTE))
		else $error("route scan finished outside a lookup");

	a_rx_count_source: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_cnt_q != $past(rx_cnt_q)) |->
		$past(accept && (req.req_type == REQ_FRAME) && !req.read_failed))
		else $error("receive counter moved without a good frame");

	a_no_add_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		rcmd.add |-> !table_full)
		else $error("route written into a full table");

endmodule
`default_nettype wire

>>> hw/rtl/canrfq_route.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// canrfq_route
// Route table in a synchronous memory, searched one entry per cycle.
// ----------------------------------------------------------------------------
module canrfq_route (
	input  wire                     clk,
	input  wire                     arst_n,
	input  canrfq_pkg::route_cmd_t  cmd,
	output canrfq_pkg::route_stat_t stat
);
	import canrfq_pkg::*;

	typedef struct packed {
		logic [10:0] key;
		logic [7:0]  handler;
	} route_entry_t;

	route_entry_t             route_mem [ROUTE_SLOTS];
	route_entry_t             entry_s1;
	logic                     cmp_s1;
	logic                     last_s1;
	logic [RouteCntW-1:0]     next_idx_q;
	logic [RouteCntW-1:0]     count_q;
	logic [10:0]              key_q;
	logic                     hit;
	logic                     rd_en;
	logic [RouteIdxW-1:0]     rd_addr;

	assign hit     = cmp_s1 && (entry_s1.key == key_q);
	assign rd_en   = cmd.lookup || (cmp_s1 && !hit && !last_s1);
	assign rd_addr = cmd.lookup ? '0 : next_idx_q[RouteIdxW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.add) begin
			route_mem[count_q[RouteIdxW-1:0]] <= '{key: cmd.key, handler: cmd.handler};
		end
		if (rd_en) begin
			entry_s1 <= route_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_s1     <= 1'b0;
			last_s1    <= 1'b0;
			next_idx_q <= '0;
			count_q    <= '0;
		end else begin
			if (cmd.add) begin
				count_q <= RouteCntW'(count_q + 1'b1);
			end
			if (cmd.lookup) begin
				cmp_s1     <= 1'b1;
				last_s1    <= (count_q == RouteCntW'(1));
				next_idx_q <= RouteCntW'(1);
			end else if (rd_en) begin
				last_s1    <= (RouteCntW'(next_idx_q + 1'b1) == count_q);
				next_idx_q <= RouteCntW'(next_idx_q + 1'b1);
			end else if (cmp_s1) begin
				cmp_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			key_q <= cmd.key;
		end
	end

	always_comb begin
		stat.done    = cmp_s1 && (hit || last_s1);
		stat.hit     = hit;
		stat.handler = entry_s1.handler;
		stat.count   = count_q;
	end

endmodule
`default_nettype wire
